// ----- rtl/core/pal_pkg.sv -----
// Shared constants, codes and types of the positional array list.
package pal_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ELEM_W   = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned FIDX_W   = 7;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LEN_W    = 8;

  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // cells per pipelined segment of the search chain
  localparam int unsigned SEG_LEN  = 8;
  localparam int unsigned NSEG     = (CAPACITY + SEG_LEN - 1) / SEG_LEN;
  localparam int unsigned SCAN_W   = $clog2(NSEG + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SET    = 3'd2,
    CMD_GET    = 3'd3,
    CMD_LOCATE = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ILLEGAL = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_WRITE  = 2'd3
  } op_e;

  // broadcast to every cell
  typedef struct packed {
    op_e               op;
    logic              locate;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [ELEM_W-1:0] value;
  } cell_ctrl_t;

  // first hit found so far along the chain
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [ELEM_W-1:0] data;
  } carry_t;

endpackage

// ----- rtl/core/pal_cmd_if.sv -----
// Command channel: valid/ready handshake with command, position and value.
interface pal_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [pal_pkg::CMD_W-1:0]   command;
  logic [pal_pkg::POS_W-1:0]   position;
  logic [pal_pkg::ELEM_W-1:0]  value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

// ----- rtl/core/pal_rsp_if.sv -----
// Response channel: valid/ready handshake with the result fields of one command.
interface pal_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pal_pkg::ELEM_W-1:0]  read_value;
  logic [pal_pkg::FIDX_W-1:0]  found_index;
  logic                        found;
  logic [pal_pkg::STAT_W-1:0]  status;
  logic [pal_pkg::LEN_W-1:0]   list_length;
  logic                        list_empty;

  modport source (output valid, read_value, found_index, found, status, list_length,
                  list_empty, input ready);
  modport sink   (input valid, read_value, found_index, found, status, list_length,
                  list_empty, output ready);
endinterface

// ----- rtl/core/pal_cell.sv -----
// One list entry: shifts from a neighbor or takes the new value, and flags a hit.
module pal_cell (
  input  logic                       clk_i,
  input  pal_pkg::cell_ctrl_t        ctrl_i,
  input  logic [pal_pkg::IDX_W-1:0]  cell_idx_i,
  input  logic [pal_pkg::ELEM_W-1:0] left_i,
  input  logic [pal_pkg::ELEM_W-1:0] right_i,
  output logic [pal_pkg::ELEM_W-1:0] data_o,
  output logic                       hit_o
);

  logic [pal_pkg::ELEM_W-1:0] data_q, data_d;
  logic [pal_pkg::POS_W-1:0]  idx_p;
  logic [pal_pkg::CNT_W-1:0]  idx_c;

  assign idx_p = pal_pkg::POS_W'(cell_idx_i);
  assign idx_c = pal_pkg::CNT_W'(cell_idx_i);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      pal_pkg::OP_INSERT: begin
        if (idx_p == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if (idx_p > ctrl_i.pos && idx_c <= ctrl_i.count) begin
          data_d = left_i;
        end
      end
      pal_pkg::OP_DELETE: begin
        if (idx_p >= ctrl_i.pos && (idx_c + pal_pkg::CNT_W'(1)) < ctrl_i.count) begin
          data_d = right_i;
        end
      end
      pal_pkg::OP_WRITE: begin
        if (idx_p == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // locate: live entry equal to the value; otherwise: entry at the position
  assign hit_o  = ctrl_i.locate ? (idx_c < ctrl_i.count && data_q == ctrl_i.value)
                                : (idx_p == ctrl_i.pos);

endmodule

// ----- rtl/core/pal_seg.sv -----
// One segment of the search chain: first hit among its cells, registered.
module pal_seg (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic [pal_pkg::SEG_LEN-1:0]                     hit_i,
  input  logic [pal_pkg::SEG_LEN-1:0][pal_pkg::ELEM_W-1:0] data_i,
  input  logic [pal_pkg::IDX_W-1:0]                       base_i,
  input  pal_pkg::carry_t                                 carry_i,
  output pal_pkg::carry_t                                 carry_o
);

  pal_pkg::carry_t carry_q, carry_d;

  always_comb begin
    carry_d = carry_i;
    for (int k = 0; k < int'(pal_pkg::SEG_LEN); k++) begin
      if (!carry_d.found && hit_i[k]) begin
        carry_d.found = 1'b1;
        carry_d.idx   = base_i + pal_pkg::IDX_W'(k);
        carry_d.data  = data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

// ----- rtl/core/positional_array_list.sv -----
// Top level of the positional array list: cell row, search chain, control and result register.
//
// An ordered list of up to CAPACITY (128) entries of 32 bits, held in a row of
// cells, one entry per cell. Each command beat carries a command, a position and
// a value: insert shifts the later entries up one cell and writes the value,
// delete returns the entry and shifts the later ones down, set overwrites an
// entry, get reads it, and locate returns the lowest index holding the value
// with a found flag. A bad position (or an unknown command) gives status 1 and
// changes nothing; insert into a full list gives status 2. Every command gives
// exactly one response beat, which also reports the list length and an empty
// flag. The block takes one command at a time. Each command waits for the hit
// search, which walks the row in segments of eight cells, one segment per
// cycle, to reach the end of the row before it completes. Shifts and writes
// happen in all cells at once in the final cycle. A finished response waits
// in an output register, so the next command is accepted while it is still
// unread; that command completes once the register is free.
// Entries start undefined after reset; only entries below the list length are
// ever read.
module positional_array_list (
  input  logic           clk_i,
  input  logic           rst_ni,
  pal_cmd_if.sink        cmd_i,
  pal_rsp_if.source      rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  localparam int unsigned PAD_LEN = pal_pkg::NSEG * pal_pkg::SEG_LEN;

  state_e state_q, state_d;
  logic [pal_pkg::SCAN_W-1:0] scan_q, scan_d;

  // command captured at accept
  logic [pal_pkg::CMD_W-1:0]  cmd_q;
  logic [pal_pkg::POS_W-1:0]  pos_q;
  logic [pal_pkg::ELEM_W-1:0] val_q;

  logic [pal_pkg::CNT_W-1:0]  count_q, count_d;

  logic accept;
  logic apply;

  pal_pkg::cell_ctrl_t ctrl;
  pal_pkg::op_e        op;

  logic [pal_pkg::ELEM_W-1:0] ent [pal_pkg::CAPACITY];
  logic [PAD_LEN-1:0]                      row_hit;
  logic [PAD_LEN-1:0][pal_pkg::ELEM_W-1:0] row_data;
  pal_pkg::carry_t carry [pal_pkg::NSEG+1];
  pal_pkg::carry_t hit_res;

  // response register
  logic                        out_valid_q, out_valid_d;
  logic [pal_pkg::ELEM_W-1:0]  rd_q, rd_d;
  logic [pal_pkg::FIDX_W-1:0]  fidx_q, fidx_d;
  logic                        fnd_q, fnd_d;
  pal_pkg::status_e            st_q, st_d;
  logic [pal_pkg::LEN_W-1:0]   len_q;

  logic full;
  logic pos_gt_cnt;
  logic pos_ge_cnt;

  // ---------------------------------------------------------------- control
  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  // completes once the search has reached the end of the row and the
  // response register is free (or being emptied this cycle)
  assign apply = (state_q == S_SCAN) && (scan_q == pal_pkg::SCAN_W'(pal_pkg::NSEG))
                 && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      S_IDLE: begin
        scan_d = '0;
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q != pal_pkg::SCAN_W'(pal_pkg::NSEG)) begin
          scan_d = scan_q + pal_pkg::SCAN_W'(1);
        end
        if (apply) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        scan_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i.command;
      pos_q <= cmd_i.position;
      val_q <= cmd_i.value;
    end
  end

  // ------------------------------------------------------------- decode
  assign full       = (count_q == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
  assign pos_gt_cnt = (pos_q >  pal_pkg::POS_W'(count_q));
  assign pos_ge_cnt = (pos_q >= pal_pkg::POS_W'(count_q));
  assign hit_res    = carry[pal_pkg::NSEG];

  always_comb begin
    op      = pal_pkg::OP_NONE;
    st_d    = pal_pkg::STAT_OK;
    rd_d    = '0;
    fnd_d   = 1'b0;
    fidx_d  = '0;
    count_d = count_q;
    unique case (cmd_q)
      pal_pkg::CMD_INSERT: begin
        if (full) begin
          st_d = pal_pkg::STAT_FULL;
        end else if (pos_gt_cnt) begin
          st_d = pal_pkg::STAT_ILLEGAL;
        end else begin
          op = pal_pkg::OP_INSERT;
          if (apply) count_d = count_q + pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_DELETE: begin
        if (pos_ge_cnt) begin
          st_d = pal_pkg::STAT_ILLEGAL;
        end else begin
          op   = pal_pkg::OP_DELETE;
          rd_d = hit_res.data;
          if (apply) count_d = count_q - pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_SET: begin
        if (pos_ge_cnt) begin
          st_d = pal_pkg::STAT_ILLEGAL;
        end else begin
          op = pal_pkg::OP_WRITE;
        end
      end
      pal_pkg::CMD_GET: begin
        if (pos_ge_cnt) begin
          st_d = pal_pkg::STAT_ILLEGAL;
        end else begin
          rd_d = hit_res.data;
        end
      end
      pal_pkg::CMD_LOCATE: begin
        fnd_d = hit_res.found;
        if (hit_res.found) begin
          fidx_d = pal_pkg::FIDX_W'(hit_res.idx);
        end
      end
      default: st_d = pal_pkg::STAT_ILLEGAL;
    endcase
  end

  assign ctrl.op     = apply ? op : pal_pkg::OP_NONE;
  assign ctrl.locate = (cmd_q == pal_pkg::CMD_LOCATE);
  assign ctrl.pos    = pos_q;
  assign ctrl.count  = count_q;
  assign ctrl.value  = val_q;

  // ------------------------------------------------------------- cell row
  for (genvar i = 0; i < int'(pal_pkg::CAPACITY); i++) begin : g_cell
    logic [pal_pkg::ELEM_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = ent[i];
    end else begin : g_mid_l
      assign left = ent[i-1];
    end
    if (i == int'(pal_pkg::CAPACITY) - 1) begin : g_last
      assign right = ent[i];
    end else begin : g_mid_r
      assign right = ent[i+1];
    end

    pal_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (pal_pkg::IDX_W'(i)),
      .left_i     (left),
      .right_i    (right),
      .data_o     (ent[i]),
      .hit_o      (row_hit[i])
    );
    assign row_data[i] = ent[i];
  end

  // segment padding when the capacity is not a multiple of the segment length
  for (genvar i = int'(pal_pkg::CAPACITY); i < int'(PAD_LEN); i++) begin : g_pad
    assign row_hit[i]  = 1'b0;
    assign row_data[i] = '0;
  end

  // ------------------------------------------------------- search chain
  assign carry[0] = '0;

  for (genvar s = 0; s < int'(pal_pkg::NSEG); s++) begin : g_seg
    pal_seg u_seg (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .hit_i   (row_hit[s*pal_pkg::SEG_LEN +: pal_pkg::SEG_LEN]),
      .data_i  (row_data[s*pal_pkg::SEG_LEN +: pal_pkg::SEG_LEN]),
      .base_i  (pal_pkg::IDX_W'(s * pal_pkg::SEG_LEN)),
      .carry_i (carry[s]),
      .carry_o (carry[s+1])
    );
  end

  // ---------------------------------------------------- response register
  always_comb begin
    out_valid_d = out_valid_q;
    if (apply) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      rd_q   <= rd_d;
      fidx_q <= fidx_d;
      fnd_q  <= fnd_d;
      st_q   <= st_d;
      len_q  <= pal_pkg::LEN_W'(count_d);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = rd_q;
  assign rsp_o.found_index = fidx_q;
  assign rsp_o.found       = fnd_q;
  assign rsp_o.status      = st_q;
  assign rsp_o.list_length = len_q;
  assign rsp_o.list_empty  = (len_q == '0);

  // ------------------------------------------------------------- checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
    else $error("list length above capacity");

  a_count_only_on_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(apply))
    else $error("list length changed outside command completion");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply |-> (!out_valid_q || rsp_o.ready))
    else $error("response overwritten before delivery");

  a_apply_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply |-> !$past(accept))
    else $error("command completed before search chain settled");

  a_locate_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && !fnd_d) |-> (fidx_d == '0))
    else $error("found index nonzero without a hit");

endmodule

// ----- dv/pal_resp_checker.sv -----
// Response checker: predicts the result of every command beat and compares response beats.
module pal_resp_checker
  import pal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pal_cmd_if          cmd_i,
  pal_rsp_if          rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] value;
  } cmd_beat_t;

  typedef struct packed {
    logic [ELEM_W-1:0] read_value;
    logic [FIDX_W-1:0] found_index;
    logic              found;
    status_e           status;
    logic [LEN_W-1:0]  list_length;
    logic              list_empty;
  } rsp_beat_t;

  // shadow copy of the list
  logic [ELEM_W-1:0] list_mem [CAPACITY];
  int unsigned       list_fill;

  rsp_beat_t         predicted_q [$];
  rsp_beat_t         oldest;
  int unsigned       mismatch_cnt = 0;
  int unsigned       rsp_num = 0;

  function automatic rsp_beat_t apply_list_command(cmd_beat_t c);
    rsp_beat_t   r;
    int unsigned p;
    int unsigned j;
    r        = '0;
    r.status = STAT_OK;
    p        = c.position;
    case (c.command)
      CMD_INSERT: begin
        // full check wins over the position check
        if (list_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (p > list_fill) begin
          r.status = STAT_ILLEGAL;
        end else begin
          for (j = list_fill; j > p; j--) list_mem[j] = list_mem[j-1];
          list_mem[p] = c.value;
          list_fill++;
        end
      end
      CMD_DELETE: begin
        if (p >= list_fill) begin
          r.status = STAT_ILLEGAL;
        end else begin
          r.read_value = list_mem[p];
          for (j = p; j + 1 < list_fill; j++) list_mem[j] = list_mem[j+1];
          list_fill--;
        end
      end
      CMD_SET: begin
        if (p >= list_fill) r.status = STAT_ILLEGAL;
        else list_mem[p] = c.value;
      end
      CMD_GET: begin
        if (p >= list_fill) r.status = STAT_ILLEGAL;
        else r.read_value = list_mem[p];
      end
      CMD_LOCATE: begin
        for (j = 0; j < list_fill && !r.found; j++) begin
          if (list_mem[j] == c.value) begin
            r.found       = 1'b1;
            r.found_index = FIDX_W'(j);
          end
        end
      end
      default: r.status = STAT_ILLEGAL;
    endcase
    r.list_length = LEN_W'(list_fill);
    r.list_empty  = (list_fill == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatch_cnt < MAX_REPORTS)
        $display("%0t: response %0d %s expected %0h got %0h", $time, rsp_num, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_fill = 0;
      predicted_q.delete();
      pending_o <= 0;
    end else begin
      // responses first: a beat at this edge always belongs to an older command
      if (rsp_i.valid && rsp_i.ready) begin
        if (predicted_q.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("%0t: response %0d with no command outstanding", $time, rsp_num);
          mismatch_cnt++;
        end else begin
          oldest = predicted_q.pop_front();
          check_field("read_value", 32'(oldest.read_value), 32'(rsp_i.read_value));
          check_field("found_index", 32'(oldest.found_index), 32'(rsp_i.found_index));
          check_field("found", 32'(oldest.found), 32'(rsp_i.found));
          check_field("status", 32'(oldest.status), 32'(rsp_i.status));
          check_field("list_length", 32'(oldest.list_length), 32'(rsp_i.list_length));
          check_field("list_empty", 32'(oldest.list_empty), 32'(rsp_i.list_empty));
        end
        rsp_num++;
      end
      if (cmd_i.valid && cmd_i.ready)
        predicted_q.push_back(apply_list_command({cmd_i.command, cmd_i.position, cmd_i.value}));
      pending_o <= predicted_q.size();
    end
  end

  assign errors_o = mismatch_cnt;

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: clock, reset, command stimulus, response back-pressure and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int unsigned CLK_HALF         = 5;
  localparam int unsigned RESET_CYCLES     = 6;
  // accept-to-response time of one command without back-pressure
  localparam int unsigned RSP_LATENCY      = NSEG + 2;
  localparam int unsigned DRAIN_CYCLES     = 4 * RSP_LATENCY;
  localparam int unsigned MAX_GAP          = 30;
  localparam int unsigned MAX_BURST        = 24;
  // long back-pressure stretch, long enough to stall the command side
  localparam int unsigned LONG_HOLD        = 400;
  // cycles with no beat on either side before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned POOL_SIZE        = 16;
  localparam int unsigned NPHASES          = 6;
  localparam int unsigned DUTY_SLOTS       = 5;
  localparam int unsigned DUTY_PERIOD      = 97;
  // command codes the block does not define
  localparam int unsigned CMD_FIRST_UNUSED = int'(CMD_LOCATE) + 1;
  localparam int unsigned CMD_LAST_UNUSED  = (1 << CMD_W) - 1;

  // command mix of a random phase
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_BALANCED,
    MIX_SHRINK
  } mix_e;

  logic clk_i;
  logic rst_ni;

  pal_cmd_if cmd_if ();
  pal_rsp_if rsp_if ();

  int unsigned errors;
  int unsigned pending;

  // bumped by the stimulus to request one long receiver hold
  int unsigned hold_ticket = 0;
  int unsigned idle_cycles = 0;

  // list length as the stimulus sees it, only used to aim positions
  int unsigned len_est = 0;
  int unsigned burst_left = 0;

  // values reused often so that locate hits and duplicates show up
  logic [ELEM_W-1:0] value_pool [POOL_SIZE];

  mix_e        phase_mix [NPHASES] = '{MIX_GROW, MIX_BALANCED, MIX_SHRINK,
                                       MIX_GROW, MIX_BALANCED, MIX_SHRINK};
  int unsigned phase_len [NPHASES] = '{300, 300, 300, 250, 250, 300};
  int unsigned duty_set [DUTY_SLOTS] = '{100, 100, 80, 45, 15};

  positional_array_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  pal_resp_checker u_resp_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: ready follows a duty cycle that is redrawn at random from duty_set;
  // 100% slots give stall-free stretches. A new hold ticket starts one long
  // hold-off counted here.
  initial begin
    int unsigned hold_left;
    int unsigned duty;
    int unsigned tick;
    int unsigned seen_ticket;
    hold_left   = 0;
    duty        = 100;
    tick        = 0;
    seen_ticket = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = LONG_HOLD;
      end
      if (tick % DUTY_PERIOD == 0) duty = duty_set[$urandom_range(0, DUTY_SLOTS - 1)];
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(1, 100) <= duty);
      end
    end
  end

  // Offer one command beat and return at the edge where it is taken. Beats go
  // out in bursts; between most bursts valid drops for a random gap.
  task automatic issue(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                       input logic [ELEM_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, MAX_BURST);
    end
    burst_left--;
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= c;
    cmd_if.position <= p;
    cmd_if.value    <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    // keep the length estimate in step so positions stay mostly legal
    if (c == CMD_INSERT && len_est < CAPACITY && p <= len_est) len_est++;
    else if (c == CMD_DELETE && p < len_est) len_est--;
  endtask

  // Weighted command choice; a small share of undefined codes always.
  function automatic logic [CMD_W-1:0] pick_command(mix_e mix);
    int unsigned r;
    int unsigned ins_w;
    int unsigned del_w;
    int unsigned rest;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin ins_w = 78; del_w = 6;  end
      MIX_SHRINK: begin ins_w = 8;  del_w = 70; end
      default:    begin ins_w = 32; del_w = 30; end
    endcase
    rest = 98 - ins_w - del_w;
    if (r < 2) return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    if (r < 2 + ins_w) return CMD_INSERT;
    if (r < 2 + ins_w + del_w) return CMD_DELETE;
    case (((r - 2 - ins_w - del_w) * 3) / rest)
      0:       return CMD_SET;
      1:       return CMD_GET;
      default: return CMD_LOCATE;
    endcase
  endfunction

  // Mostly legal positions, biased to both ends, plus off-by-one and noise.
  function automatic logic [POS_W-1:0] pick_position(logic [CMD_W-1:0] c, int unsigned len);
    int unsigned span;
    int unsigned r;
    span = (c == CMD_INSERT) ? len : ((len == 0) ? 0 : len - 1);
    r    = $urandom_range(0, 99);
    if (r < 10) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    if (r < 14) return POS_W'(len);
    if (r < 17) return POS_W'(len + 1);
    if (r < 27) return POS_W'(span);
    if (r < 33) return '0;
    return POS_W'($urandom_range(0, span));
  endfunction

  function automatic logic [ELEM_W-1:0] pick_value(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return ELEM_W'($urandom());
  endfunction

  // Stimulus: reset, directed beats, random phases, drain and verdict.
  initial begin
    int unsigned      ph;
    int unsigned      k;
    logic [CMD_W-1:0] c;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CMD_GET;
    cmd_if.position <= '0;
    cmd_if.value    <= '0;
    rst_ni          <= 1'b0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) value_pool[k] = ELEM_W'($urandom());

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // everything on an empty list is illegal except locate, which misses
    issue(CMD_GET,    8'd0, 32'h0);
    issue(CMD_DELETE, 8'd0, 32'h0);
    issue(CMD_SET,    8'd0, 32'h1);
    issue(CMD_LOCATE, 8'd0, 32'h0);
    // insert just past the end is rejected
    issue(CMD_INSERT, 8'd1, 32'h1);
    // front, end, middle and front again: 80000001 ffffffff 5a5a5a5a 00000000
    issue(CMD_INSERT, 8'd0, 32'hffff_ffff);
    issue(CMD_INSERT, 8'd1, 32'h0);
    issue(CMD_INSERT, 8'd1, 32'h5a5a_5a5a);
    issue(CMD_INSERT, 8'd0, 32'h8000_0001);
    // last entry, then one past it
    issue(CMD_GET,    8'd3, 32'h0);
    issue(CMD_GET,    8'd4, 32'h0);
    issue(CMD_SET,    8'd2, 32'h1234_5678);
    // hits deep and shallow, and a miss
    issue(CMD_LOCATE, 8'd0, 32'h0);
    issue(CMD_LOCATE, 8'd0, 32'hdead_beef);
    issue(CMD_LOCATE, 8'd0, 32'hffff_ffff);
    // position field extremes
    issue(CMD_GET,    8'd255, 32'h0);
    issue(CMD_INSERT, 8'd128, 32'h0);
    issue(CMD_SET,    8'd255, 32'hffff_ffff);
    // undefined command codes change nothing
    for (k = CMD_FIRST_UNUSED; k <= CMD_LAST_UNUSED; k++) issue(CMD_W'(k), 8'd0, 32'hffff_ffff);
    // delete from the end, the front, the end and the front down to empty
    issue(CMD_DELETE, 8'd3, 32'h0);
    issue(CMD_DELETE, 8'd0, 32'h0);
    issue(CMD_DELETE, 8'd1, 32'h0);
    issue(CMD_DELETE, 8'd0, 32'h0);

    // --- random phases ---
    // grow phases run the list into the full limit, shrink phases back to
    // empty; between phases the sender waits until every response is in.
    for (ph = 0; ph < NPHASES; ph++) begin
      for (k = 0; k < phase_len[ph]; k++) begin
        // one long receiver hold while commands keep coming
        if (ph == 3 && k == 40) hold_ticket <= hold_ticket + 1;
        c = pick_command(phase_mix[ph]);
        issue(c, pick_position(c, len_est), pick_value((c == CMD_LOCATE) ? 70 : 50));
      end
      cmd_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clk_i); while (pending != 0);
    end

    // everything is drained; leave time for any stray beat to show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
